// ===== design/nmea_rmc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nmea_rmc_pkg
// Shared constants, types and helper functions for the NMEA RMC checker.
// ---------------------------------------------------------------------------
package nmea_rmc_pkg;

    localparam int MAX_SENTENCE    = 82;
    localparam int FIELD_MAX       = 25;
    localparam int FRAC_DIGITS_MAX = 7;

    localparam int CNT_W  = $clog2(MAX_SENTENCE + 2);
    localparam int FPOS_W = $clog2(FIELD_MAX);
    localparam int FCNT_W = 4;   // holds FRAC_DIGITS_MAX up to 15
    localparam int ACC_W  = 24;  // widest accumulator
    localparam int MAC_W  = 28;  // acc * 10 + 9

    localparam logic [MAC_W-1:0] TIME_SAT = MAC_W'(999999);
    localparam logic [MAC_W-1:0] LAT_SAT  = MAC_W'(9000);
    localparam logic [MAC_W-1:0] LON_SAT  = MAC_W'(18000);
    localparam logic [MAC_W-1:0] FRAC_SAT = MAC_W'(9999999);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_RMC   = 2'd1,
        KIND_VTG   = 2'd2
    } kind_t;

    // Field codes of the RMC sentence that carry data, and FLD_SAT where the count stops
    localparam logic [4:0] FLD_TIME   = 5'd1;
    localparam logic [4:0] FLD_STATUS = 5'd2;
    localparam logic [4:0] FLD_LAT    = 5'd3;
    localparam logic [4:0] FLD_NS     = 5'd4;
    localparam logic [4:0] FLD_LON    = 5'd5;
    localparam logic [4:0] FLD_EW     = 5'd6;
    localparam logic [4:0] FLD_SAT    = 5'd31;

    typedef struct packed {
        logic         checksum_ok;
        kind_t        sentence_kind;
        logic         fix_valid;
        logic [19:0]  fix_time;
        logic [14:0]  lat_whole;
        logic [23:0]  lat_fraction;
        logic [2:0]   lat_fraction_digits;
        logic [15:0]  lon_whole;
        logic [23:0]  lon_fraction;
        logic [2:0]   lon_fraction_digits;
        logic [6:0]   sentence_length;
        logic         overrun;
    } report_t;

    // Header characters after '$' (positions 1..5)
    function automatic logic [7:0] hdr_rmc_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd1:    ch = 8'h47;  // G
            3'd2:    ch = 8'h50;  // P
            3'd3:    ch = 8'h52;  // R
            3'd4:    ch = 8'h4D;  // M
            3'd5:    ch = 8'h43;  // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] hdr_vtg_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd1:    ch = 8'h47;  // G
            3'd2:    ch = 8'h50;  // P
            3'd3:    ch = 8'h56;  // V
            3'd4:    ch = 8'h54;  // T
            3'd5:    ch = 8'h47;  // G
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // {bad, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else begin
            r = 5'b10000;
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ===== design/nmea_rmc_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nmea_rmc_core
// Per-character sentence state: checksum, header match, field accumulators.
// ---------------------------------------------------------------------------
module nmea_rmc_core
    import nmea_rmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,        // consume rx_byte this cycle
    input  logic [7:0] rx_byte,
    output logic       will_report, // rx_byte closes an open sentence
    output report_t    report
);

    logic                in_sentence_reg, in_sentence_next;
    logic [CNT_W-1:0]    char_count_reg, char_count_next;
    logic [7:0]          xor_reg, xor_next;
    logic [1:0]          hdr_reg, hdr_next;
    logic [4:0]          field_reg, field_next;
    logic [1:0]          star_reg, star_next;
    logic [7:0]          given_reg, given_next;
    logic                hex_bad_reg, hex_bad_next;
    logic                point_reg, point_next;
    logic                status_a_reg, status_a_next;
    logic                north_reg, north_next;
    logic                east_reg, east_next;
    logic [19:0]         time_reg, time_next;
    logic [13:0]         lat_int_reg, lat_int_next;
    logic [23:0]         lat_frac_reg, lat_frac_next;
    logic [14:0]         lon_int_reg, lon_int_next;
    logic [23:0]         lon_frac_reg, lon_frac_next;
    logic [FCNT_W-1:0]   lat_fcnt_reg, lat_fcnt_next;
    logic [FCNT_W-1:0]   lon_fcnt_reg, lon_fcnt_next;
    logic [FPOS_W-1:0]   fpos_reg, fpos_next;
    logic                stop_reg, stop_next;

    // shared multiply-by-ten with saturation
    logic [ACC_W-1:0]    mac_acc;
    logic [MAC_W-1:0]    mac_lim;
    logic [MAC_W-1:0]    mac_raw;
    logic [MAC_W-1:0]    mac_sat;
    logic [3:0]          digit;

    logic                is_ws;
    logic                coord_lon;
    logic [FCNT_W-1:0]   fcnt_cur;
    logic [4:0]          hex;
    logic [2:0]          hdr_pos;

    // report side
    logic                ovr;
    logic                fix;
    kind_t               kind;
    logic [31:0]         len_w;

    assign digit     = rx_byte[3:0];
    assign is_ws     = (rx_byte == CH_LF) || (rx_byte == CH_CR) ||
                       (rx_byte == CH_SP) || (rx_byte == CH_TAB);
    assign coord_lon = (field_reg == FLD_LON);
    assign fcnt_cur  = coord_lon ? lon_fcnt_reg : lat_fcnt_reg;
    assign hex       = hex_decode(rx_byte);
    assign hdr_pos   = 3'(char_count_reg);

    always_comb begin
        mac_acc = '0;
        mac_lim = TIME_SAT;
        unique case (field_reg)
            FLD_LAT: begin
                mac_acc = point_reg ? lat_frac_reg : ACC_W'(lat_int_reg);
                mac_lim = point_reg ? FRAC_SAT : LAT_SAT;
            end
            FLD_LON: begin
                mac_acc = point_reg ? lon_frac_reg : ACC_W'(lon_int_reg);
                mac_lim = point_reg ? FRAC_SAT : LON_SAT;
            end
            default: begin
                mac_acc = ACC_W'(time_reg);
                mac_lim = TIME_SAT;
            end
        endcase
        mac_raw = {1'b0, mac_acc, 3'b000} + {3'b000, mac_acc, 1'b0} + MAC_W'(digit);
        mac_sat = (mac_raw > mac_lim) ? mac_lim : mac_raw;
    end

    always_comb begin
        in_sentence_next = in_sentence_reg;
        char_count_next  = char_count_reg;
        xor_next         = xor_reg;
        hdr_next         = hdr_reg;
        field_next       = field_reg;
        star_next        = star_reg;
        given_next       = given_reg;
        hex_bad_next     = hex_bad_reg;
        point_next       = point_reg;
        status_a_next    = status_a_reg;
        north_next       = north_reg;
        east_next        = east_reg;
        time_next        = time_reg;
        lat_int_next     = lat_int_reg;
        lat_frac_next    = lat_frac_reg;
        lon_int_next     = lon_int_reg;
        lon_frac_next    = lon_frac_reg;
        lat_fcnt_next    = lat_fcnt_reg;
        lon_fcnt_next    = lon_fcnt_reg;
        fpos_next        = fpos_reg;
        stop_next        = stop_reg;

        if (step) begin
            if (rx_byte == CH_DOLLAR) begin
                in_sentence_next = 1'b1;
                char_count_next  = CNT_W'(1);
                xor_next         = '0;
                hdr_next         = '0;
                field_next       = '0;
                star_next        = '0;
                given_next       = '0;
                hex_bad_next     = 1'b0;
                point_next       = 1'b0;
                status_a_next    = 1'b0;
                north_next       = 1'b0;
                east_next        = 1'b0;
                time_next        = '0;
                lat_int_next     = '0;
                lat_frac_next    = '0;
                lon_int_next     = '0;
                lon_frac_next    = '0;
                lat_fcnt_next    = '0;
                lon_fcnt_next    = '0;
                fpos_next        = '0;
                stop_next        = 1'b0;
            end else if (!is_ws && in_sentence_reg) begin
                if (char_count_reg >= CNT_W'(MAX_SENTENCE)) begin
                    char_count_next = CNT_W'(MAX_SENTENCE + 1);
                end else begin
                    char_count_next = char_count_reg + CNT_W'(1);
                    if (char_count_reg >= CNT_W'(1) && char_count_reg <= CNT_W'(5)) begin
                        if (rx_byte != hdr_rmc_char(hdr_pos)) hdr_next[0] = 1'b1;
                        if (rx_byte != hdr_vtg_char(hdr_pos)) hdr_next[1] = 1'b1;
                    end
                    if (star_reg != 2'd0) begin
                        if (star_reg == 2'd3 || hex[4]) begin
                            hex_bad_next = 1'b1;
                        end else begin
                            given_next = {given_reg[3:0], hex[3:0]};
                            star_next  = star_reg + 2'd1;
                        end
                    end else if (rx_byte == CH_STAR) begin
                        star_next = 2'd1;
                    end else begin
                        xor_next = xor_reg ^ rx_byte;
                        if (rx_byte == CH_COMMA) begin
                            if (field_reg != FLD_SAT) field_next = field_reg + 5'd1;
                            fpos_next  = '0;
                            point_next = 1'b0;
                            stop_next  = 1'b0;
                        end else if (fpos_reg < FPOS_W'(FIELD_MAX - 1)) begin
                            fpos_next = fpos_reg + FPOS_W'(1);
                            unique case (field_reg)
                                FLD_TIME: begin
                                    if (!stop_reg) begin
                                        if (is_digit(rx_byte)) time_next = mac_sat[19:0];
                                        else stop_next = 1'b1;
                                    end
                                end
                                FLD_STATUS: begin
                                    if (fpos_reg == '0) status_a_next = (rx_byte == CH_A);
                                end
                                FLD_NS: begin
                                    if (fpos_reg == '0) north_next = (rx_byte == CH_N);
                                end
                                FLD_EW: begin
                                    if (fpos_reg == '0) east_next = (rx_byte == CH_E);
                                end
                                FLD_LAT, FLD_LON: begin
                                    if (rx_byte == CH_DOT) begin
                                        if (!point_reg) begin
                                            point_next = 1'b1;
                                            stop_next  = 1'b0;
                                        end else begin
                                            stop_next = 1'b1;
                                        end
                                    end else if (rx_byte == CH_MINUS) begin
                                        // sign characters are skipped
                                    end else if (is_digit(rx_byte)) begin
                                        if (!stop_reg) begin
                                            if (!point_reg) begin
                                                if (coord_lon) lon_int_next = mac_sat[14:0];
                                                else lat_int_next = mac_sat[13:0];
                                            end else if (fcnt_cur <
                                                         FCNT_W'(FRAC_DIGITS_MAX)) begin
                                                if (coord_lon) begin
                                                    lon_frac_next = mac_sat[23:0];
                                                    lon_fcnt_next = lon_fcnt_reg + FCNT_W'(1);
                                                end else begin
                                                    lat_frac_next = mac_sat[23:0];
                                                    lat_fcnt_next = lat_fcnt_reg + FCNT_W'(1);
                                                end
                                            end
                                        end
                                    end else begin
                                        stop_next = 1'b1;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg <= 1'b0;
            char_count_reg  <= '0;
            xor_reg         <= '0;
            hdr_reg         <= '0;
            field_reg       <= '0;
            star_reg        <= '0;
            given_reg       <= '0;
            hex_bad_reg     <= 1'b0;
            point_reg       <= 1'b0;
            status_a_reg    <= 1'b0;
            north_reg       <= 1'b0;
            east_reg        <= 1'b0;
            time_reg        <= '0;
            lat_int_reg     <= '0;
            lat_frac_reg    <= '0;
            lon_int_reg     <= '0;
            lon_frac_reg    <= '0;
            lat_fcnt_reg    <= '0;
            lon_fcnt_reg    <= '0;
            fpos_reg        <= '0;
            stop_reg        <= 1'b0;
        end else begin
            in_sentence_reg <= in_sentence_next;
            char_count_reg  <= char_count_next;
            xor_reg         <= xor_next;
            hdr_reg         <= hdr_next;
            field_reg       <= field_next;
            star_reg        <= star_next;
            given_reg       <= given_next;
            hex_bad_reg     <= hex_bad_next;
            point_reg       <= point_next;
            status_a_reg    <= status_a_next;
            north_reg       <= north_next;
            east_reg        <= east_next;
            time_reg        <= time_next;
            lat_int_reg     <= lat_int_next;
            lat_frac_reg    <= lat_frac_next;
            lon_int_reg     <= lon_int_next;
            lon_frac_reg    <= lon_frac_next;
            lat_fcnt_reg    <= lat_fcnt_next;
            lon_fcnt_reg    <= lon_fcnt_next;
            fpos_reg        <= fpos_next;
            stop_reg        <= stop_next;
        end
    end

    // Report for the sentence held in state (valid when a '$' arrives)
    assign will_report = in_sentence_reg && (rx_byte == CH_DOLLAR);
    assign ovr = (char_count_reg > CNT_W'(MAX_SENTENCE));
    assign len_w = ovr ? 32'(MAX_SENTENCE) : 32'(char_count_reg);

    always_comb begin
        kind = KIND_OTHER;
        if (char_count_reg >= CNT_W'(6)) begin
            if (!hdr_reg[0]) kind = KIND_RMC;
            else if (!hdr_reg[1]) kind = KIND_VTG;
        end
        fix = (kind == KIND_RMC) && status_a_reg;

        report.checksum_ok   = !ovr && (star_reg == 2'd3) && !hex_bad_reg &&
                               (given_reg == xor_reg);
        report.sentence_kind = kind;
        report.fix_valid     = fix;
        report.fix_time      = fix ? time_reg : '0;
        report.lat_whole     = !fix ? '0 :
                               north_reg ? {1'b0, lat_int_reg} : 15'(-{1'b0, lat_int_reg});
        report.lat_fraction  = fix ? lat_frac_reg : '0;
        report.lat_fraction_digits = fix ? lat_fcnt_reg[2:0] : '0;
        report.lon_whole     = !fix ? '0 :
                               east_reg ? {1'b0, lon_int_reg} : 16'(-{1'b0, lon_int_reg});
        report.lon_fraction  = fix ? lon_frac_reg : '0;
        report.lon_fraction_digits = fix ? lon_fcnt_reg[2:0] : '0;
        report.sentence_length = len_w[6:0];
        report.overrun       = ovr;
    end

endmodule

// ===== design/nmea_rmc_out_reg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nmea_rmc_out_reg
// Result register: holds one report beat until the sink takes it.
// ---------------------------------------------------------------------------
module nmea_rmc_out_reg
    import nmea_rmc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,      // only asserted when free or being drained
    input  report_t load_data,
    output logic    busy,      // full and not drained this cycle
    output logic    out_valid,
    input  logic    out_ready,
    output report_t out_data
);

    logic    valid_reg, valid_next;
    report_t data_reg;

    assign busy = valid_reg && !out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) valid_next = 1'b1;
        else if (out_ready) valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/nmea_sentence_checker_rmc_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nmea_sentence_checker_rmc_parser
// NMEA 0183 checksum checker with GPRMC time / position extraction.
// ---------------------------------------------------------------------------
//
//  Channel | Dir | Beat contents                     | Per beat
//  --------+-----+-----------------------------------+------------------------
//  s_      | in  | one received character            | updates sentence state
//  m_      | out | one report per closed sentence    | issued when '$' arrives
//
//  Cycles: one character per cycle sustained unless a closing '$' stalls
//  (see Stalls). A character passes through the input register and is then
//  folded into the sentence state; a '$' that closes a sentence loads its
//  report into the result register at that same edge, which drives m_tvalid.
//  Reset: aresetn low clears the input valid, the sentence state and the
//  result valid; characters before the first '$' are discarded.
//  Stalls: only a closing '$' waits, and only while the result register
//  holds a report that m_tready does not take; other characters keep
//  flowing while a report waits.
//
module nmea_sentence_checker_rmc_parser
    import nmea_rmc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte

    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] checksum_ok, [1] fix_valid, [21:2] fix_time, [36:22] lat_whole,
    // [60:37] lat_fraction, [63:61] lat_fraction_digits, [79:64] lon_whole,
    // [103:80] lon_fraction, [106:104] lon_fraction_digits,
    // [113:107] sentence_length, [114] overrun, [119:115] zero
    output logic [119:0] m_tdata,
    output logic [1:0]   m_tuser    // [1:0] sentence_kind
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    logic       will_report;
    logic       advance;     // held character may be consumed this cycle
    logic       step;
    logic       out_busy;
    report_t    core_report;
    report_t    out_report;

    // A closing '$' needs room in the result register; everything else moves.
    assign advance  = !(will_report && out_busy);
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    nmea_rmc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .will_report (will_report),
        .report      (core_report)
    );

    nmea_rmc_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && will_report),
        .load_data (core_report),
        .busy      (out_busy),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_report)
    );

    assign m_tdata = {5'b00000,
                      out_report.overrun,
                      out_report.sentence_length,
                      out_report.lon_fraction_digits,
                      out_report.lon_fraction,
                      out_report.lon_whole,
                      out_report.lat_fraction_digits,
                      out_report.lat_fraction,
                      out_report.lat_whole,
                      out_report.fix_time,
                      out_report.fix_valid,
                      out_report.checksum_ok};
    assign m_tuser = out_report.sentence_kind;

endmodule
